/* sv/angle_between_three_points_macros.svh */
// assertion macros for the angle_between_three_points block
// used by the top level; expects signals named clk and arst_n in scope
`ifndef ANGLE_BETWEEN_THREE_POINTS_MACROS_SVH
`define ANGLE_BETWEEN_THREE_POINTS_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ABTP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked in the same cycle
`define ABTP_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* sv/abtp_pkg.sv */
// shared constants, widths and the arctangent table for the angle block
// no dependencies
`default_nettype none

package abtp_pkg;

	localparam int COORD_WIDTH     = 16;
	localparam int ANGLE_FRAC_BITS = 15;
	localparam int CORDIC_STEPS    = 31;

	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int VEC_W   = 64;
	localparam int SCALE   = 59 - COORD_WIDTH;
	localparam int DIR_W   = 32;
	localparam int ANGLE_W = ANGLE_FRAC_BITS + 1;

	localparam int IN_W  = ((6 * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_W = ((ANGLE_W + 7) / 8) * 8;

	// register stages: diff, prescale, cordic steps, fold, round
	localparam int LAT = CORDIC_STEPS + 4;

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic [DIR_W-1:0]         dir_t;
	typedef logic [ANGLE_W-1:0]       angle_t;

	// round(atan(2^-k) * 2^31 / pi)
	function automatic dir_t atan_entry(input int k);
		dir_t r;
		case (k)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			24: r = 32'h00000029;
			25: r = 32'h00000014;
			26: r = 32'h0000000A;
			27: r = 32'h00000005;
			28: r = 32'h00000003;
			29: r = 32'h00000001;
			30: r = 32'h00000001;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/angle_between_three_points.sv */
// Angle between the vectors OP and OQ, returned as a fraction of pi
// (angle * pi / 2^15) with a degenerate flag when either vector is zero.
// Each item passes through 35 register stages: a difference stage, a
// prescale stage, one stage per cordic step (31), a fold stage and a round
// stage; both directions are found by two cordic pipelines side by side.
// One item is accepted every cycle unless the output stalls; a stall at the
// output freezes the whole pipeline.
// uses abtp_pkg, abtp_cordic and angle_between_three_points_macros.svh
`default_nettype none

`include "angle_between_three_points_macros.svh"

module angle_between_three_points (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output      logic                       s_tready,
	// origin_x, origin_y, first_x, first_y, second_x, second_y
	input  wire logic [abtp_pkg::IN_W-1:0]  s_tdata,
	output      logic                       m_tvalid,
	input  wire logic                       m_tready,
	// angle, zero filled
	output      logic [abtp_pkg::OUT_W-1:0] m_tdata,
	// degenerate
	output      logic                       m_tuser
);
	import abtp_pkg::*;

	logic en;
	logic vld_s [1:LAT];
	logic deg_s [1:LAT];

	diff_t px_s1, py_s1, qx_s1, qy_s1;
	dir_t  dp, dq;
	dir_t  m_s34;
	logic  [DIR_W:0] m_full;
	angle_t angle_s35;

	logic signed [COORD_WIDTH-1:0] ox, oy, fx, fy, sx, sy;
	diff_t px, py, qx, qy;

	assign en       = !vld_s[LAT] || m_tready;
	assign s_tready = en;

	always_comb begin
		ox = s_tdata[0*COORD_WIDTH +: COORD_WIDTH];
		oy = s_tdata[1*COORD_WIDTH +: COORD_WIDTH];
		fx = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
		fy = s_tdata[3*COORD_WIDTH +: COORD_WIDTH];
		sx = s_tdata[4*COORD_WIDTH +: COORD_WIDTH];
		sy = s_tdata[5*COORD_WIDTH +: COORD_WIDTH];
		px = diff_t'(fx) - diff_t'(ox);
		py = diff_t'(fy) - diff_t'(oy);
		qx = diff_t'(sx) - diff_t'(ox);
		qy = diff_t'(sy) - diff_t'(oy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= s_tvalid;
			for (int i = 2; i <= LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1    <= px;
			py_s1    <= py;
			qx_s1    <= qx;
			qy_s1    <= qy;
			deg_s[1] <= (px == '0 && py == '0) || (qx == '0 && qy == '0);
			for (int i = 2; i <= LAT; i++) begin
				deg_s[i] <= deg_s[i-1];
			end
		end
	end

	abtp_cordic u_cordic_p (
		.clk (clk),
		.en  (en),
		.dx  (px_s1),
		.dy  (py_s1),
		.dir (dp)
	);

	abtp_cordic u_cordic_q (
		.clk (clk),
		.en  (en),
		.dx  (qx_s1),
		.dy  (qy_s1),
		.dir (dq)
	);

	// fold the wrapped difference into [0, pi]
	always_ff @(posedge clk) begin
		if (en) begin
			if ((dq - dp) <= dir_t'(32'h80000000)) begin
				m_s34 <= dq - dp;
			end else begin
				m_s34 <= dp - dq;
			end
		end
	end

	// round to nearest, ties upward
	assign m_full = {1'b0, m_s34} + ((DIR_W+1)'(1) << (30 - ANGLE_FRAC_BITS));

	always_ff @(posedge clk) begin
		if (en) begin
			if (deg_s[LAT-1]) begin
				angle_s35 <= '0;
			end else begin
				angle_s35 <= m_full[31-ANGLE_FRAC_BITS +: ANGLE_W];
			end
		end
	end

	assign m_tvalid = vld_s[LAT];
	assign m_tdata  = OUT_W'(angle_s35);
	assign m_tuser  = deg_s[LAT];

	`ABTP_ASSERT_IMPL(a_deg_zero, m_tvalid && m_tuser, angle_s35 == '0, "degenerate item with nonzero angle")
	`ABTP_ASSERT_IMPL(a_angle_max, m_tvalid, angle_s35 <= (ANGLE_W'(1) << ANGLE_FRAC_BITS), "angle above pi")
	`ABTP_ASSERT(a_ready_stall, (m_tvalid && !m_tready) == !s_tready, "input ready does not follow output stall")

endmodule

`default_nettype wire

/* sv/abtp_cordic.sv */
// pipelined cordic in vectoring mode: direction of one difference vector
// uses abtp_pkg; one micro-rotation per register stage
`default_nettype none

module abtp_cordic (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire abtp_pkg::diff_t dx,
	input  wire abtp_pkg::diff_t dy,
	output      abtp_pkg::dir_t  dir
);
	import abtp_pkg::*;

	vec_t x_s   [0:CORDIC_STEPS];
	vec_t y_s   [0:CORDIC_STEPS];
	dir_t acc_s [0:CORDIC_STEPS];

	vec_t x_pre, y_pre;

	always_comb begin
		x_pre = vec_t'(dx) <<< SCALE;
		y_pre = vec_t'(dy) <<< SCALE;
	end

	// fold the left half plane onto the right one
	always_ff @(posedge clk) begin
		if (en) begin
			if (x_pre < 0) begin
				x_s[0]   <= -x_pre;
				y_s[0]   <= -y_pre;
				acc_s[0] <= dir_t'(32'h80000000);
			end else begin
				x_s[0]   <= x_pre;
				y_s[0]   <= y_pre;
				acc_s[0] <= '0;
			end
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		vec_t xs, ys;
		assign xs = x_s[k] >>> k;
		assign ys = y_s[k] >>> k;

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[k] > 0) begin
					x_s[k+1]   <= x_s[k] + ys;
					y_s[k+1]   <= y_s[k] - xs;
					acc_s[k+1] <= acc_s[k] + atan_entry(k);
				end else begin
					x_s[k+1]   <= x_s[k] - ys;
					y_s[k+1]   <= y_s[k] + xs;
					acc_s[k+1] <= acc_s[k] - atan_entry(k);
				end
			end
		end
	end

	assign dir = acc_s[CORDIC_STEPS];

endmodule

`default_nettype wire
